>>> hw/rtl/slpq_pkg.sv
// ----------------------------------------------------------------------------
// slpq_pkg
// Shared types and constants of the sorted-list priority queue: opcodes,
// status codes, the command word between front and back, and sequencer states.
// ----------------------------------------------------------------------------
package slpq_pkg;

	// default number of stored values
	localparam int unsigned DEF_CAPACITY = 32;
	// default depth of the command queue between front and back
	localparam int unsigned DEF_QUEUE_DEPTH = 2;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned STATUS_W = 2;

	// opcodes carried in the input tuser
	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 3'd0,
		OP_PEEK   = 3'd1,
		OP_POP    = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_LIST   = 3'd4
	} op_t;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// decoded command handed from front to back
	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0]  value;
	} cmd_t;

	// back sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_LIST
	} bk_state_t;

endpackage

>>> hw/rtl/slpq_front.sv
// ----------------------------------------------------------------------------
// slpq_front
// Input side: accepts words, decodes the opcode, drops unknown opcodes and
// holds one decoded command until the command queue takes it.
// ----------------------------------------------------------------------------
module slpq_front import slpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
	input  logic [OPCODE_W-1:0] s_tuser,   // [2:0] opcode
	output logic                cmd_vld,
	input  logic                cmd_rdy,
	output cmd_t                cmd
);

	logic vld_s1;
	cmd_t cmd_s1;
	logic known;
	logic accept;

	// opcode classification
	always_comb begin
		case (s_tuser)
			OP_INSERT, OP_PEEK, OP_POP, OP_CLEAR, OP_LIST: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	assign s_tready = !vld_s1 || cmd_rdy;
	assign accept   = s_tvalid && s_tready;

	// stage register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (accept && known) || (vld_s1 && !cmd_rdy);
		end
	end

	// stage register payload
	always_ff @(posedge clk) begin
		if (accept && known) begin
			cmd_s1.op    <= op_t'(s_tuser);
			cmd_s1.value <= $signed(s_tdata);
		end
	end

	assign cmd_vld = vld_s1;
	assign cmd     = cmd_s1;

endmodule

>>> hw/rtl/slpq_cmd_queue.sv
// ----------------------------------------------------------------------------
// slpq_cmd_queue
// Short first-in first-out queue of decoded commands that lets the front and
// the back stall independently.
// ----------------------------------------------------------------------------
module slpq_cmd_queue import slpq_pkg::*; #(
	parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_vld,
	output logic push_rdy,
	input  cmd_t push_cmd,
	output logic pop_vld,
	input  logic pop_rdy,
	output cmd_t pop_cmd
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t            slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	assign push_rdy = fill_q != CW'(DEPTH);
	assign pop_vld  = fill_q != '0;
	assign do_push  = push_vld && push_rdy;
	assign do_pop   = pop_vld && pop_rdy;
	assign pop_cmd  = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> hw/rtl/slpq_back.sv
// ----------------------------------------------------------------------------
// slpq_back
// Execution side: a row of compare-and-shift cells holding the sorted values,
// the entry count, a list sequencer and the registered output word.
// ----------------------------------------------------------------------------
module slpq_back import slpq_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_vld,
	output logic                cmd_rdy,
	input  cmd_t                cmd,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [VALUE_W-1:0]  m_tdata,   // [31:0] data
	output logic [STATUS_W-1:0] m_tuser,   // [1:0] status
	output logic                m_tlast
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic signed [VALUE_W-1:0] cell_q   [CAPACITY];
	logic signed [VALUE_W-1:0] ins_val  [CAPACITY];
	logic signed [VALUE_W-1:0] shf_val  [CAPACITY];
	logic signed [VALUE_W-1:0] rot_val  [CAPACITY];
	logic [CAPACITY-1:0]       lt;

	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     left_q, left_d;
	bk_state_t         state_q, state_d;

	logic              out_vld_q;
	logic [VALUE_W-1:0]  out_data_q, out_data_d;
	logic [STATUS_W-1:0] out_status_q, out_status_d;
	logic              out_last_q, out_last_d;
	logic              out_free;
	logic              out_load;

	logic              do_insert;
	logic              do_shift;
	logic              do_rotate;
	logic              take;
	logic              empty;
	logic              full;

	// per-cell next values for insert, pop shift and list rotation
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign lt[i] = (CW'(i) < count_q) && (cell_q[i] < cmd.value);
		if (i == 0) begin : g_head
			assign ins_val[i] = lt[i] ? cell_q[i] : cmd.value;
		end else begin : g_body
			assign ins_val[i] = lt[i] ? cell_q[i] : (lt[i-1] ? cmd.value : cell_q[i-1]);
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign shf_val[i] = cell_q[i];
		end else begin : g_mid
			assign shf_val[i] = cell_q[i+1];
		end
		assign rot_val[i] = (CW'(i) == count_q - 1'b1) ? cell_q[0] : shf_val[i];

		always_ff @(posedge clk) begin
			if (do_insert) begin
				cell_q[i] <= ins_val[i];
			end else if (do_shift) begin
				cell_q[i] <= shf_val[i];
			end else if (do_rotate) begin
				cell_q[i] <= rot_val[i];
			end
		end
	end

	assign out_free = !out_vld_q || m_tready;
	assign cmd_rdy  = out_free && (state_q == BK_IDLE);
	assign take     = cmd_vld && cmd_rdy;
	assign empty    = count_q == '0;
	assign full     = count_q == CW'(CAPACITY);

	// sequencer next state and actions
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		left_d       = left_q;
		do_insert    = 1'b0;
		do_shift     = 1'b0;
		do_rotate    = 1'b0;
		out_load     = 1'b0;
		out_data_d   = '0;
		out_status_d = ST_OK;
		out_last_d   = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (take) begin
					out_load = 1'b1;
					case (cmd.op)
						OP_INSERT: begin
							if (full) begin
								out_status_d = ST_FULL;
							end else begin
								do_insert = 1'b1;
								count_d   = count_q + 1'b1;
							end
						end
						OP_PEEK: begin
							if (empty) out_status_d = ST_EMPTY;
							else       out_data_d   = cell_q[0];
						end
						OP_POP: begin
							if (empty) begin
								out_status_d = ST_EMPTY;
							end else begin
								out_data_d = cell_q[0];
								do_shift   = 1'b1;
								count_d    = count_q - 1'b1;
							end
						end
						OP_CLEAR: begin
							count_d = '0;
						end
						OP_LIST: begin
							if (empty) begin
								out_status_d = ST_EMPTY;
							end else begin
								out_data_d = cell_q[0];
								do_rotate  = 1'b1;
								out_last_d = count_q == CW'(1);
								left_d     = count_q - 1'b1;
								if (count_q != CW'(1)) state_d = BK_LIST;
							end
						end
						default: begin
							out_load = 1'b0;
						end
					endcase
				end
			end
			BK_LIST: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_data_d = cell_q[0];
					do_rotate  = 1'b1;
					out_last_d = left_q == CW'(1);
					left_d     = left_q - 1'b1;
					if (left_q == CW'(1)) state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			count_q   <= '0;
			left_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			left_q  <= left_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= out_data_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	// count never exceeds the cell row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// a list run only happens with a non-empty store and words still to send
	a_list_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_LIST |-> (count_q != '0) && (left_q != '0) && (left_q < count_q))
		else $error("list run with bad counters");

	// a clear leaves the store empty
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd.op == OP_CLEAR |=> count_q == '0)
		else $error("clear did not empty the store");

	// no output word is overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output word overwritten");
`endif

endmodule

>>> hw/rtl/sorted_list_priority_queue.sv
// Path: an accepted command passes the front stage register and the command queue; the
// cell row then loads the output register, which drives the master side.
// Insert, peek, pop and clear each act in the cell row when taken, one word each; list sends
// one word per stored value through the single output register, taking no command meanwhile.
// Unknown opcodes are accepted and produce no word.
// Reset: control state and the entry count clear at once; the cell row is not cleared.
// ----------------------------------------------------------------------------
// sorted_list_priority_queue
// Priority queue of signed 32-bit values kept in ascending order in a row of
// compare-and-shift cells, with a decoupled front end and command queue.
// ----------------------------------------------------------------------------
module sorted_list_priority_queue import slpq_pkg::*; #(
	parameter int unsigned CAPACITY    = DEF_CAPACITY,
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
	input  logic [OPCODE_W-1:0] s_tuser,   // [2:0] opcode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [VALUE_W-1:0]  m_tdata,   // [31:0] data
	output logic [STATUS_W-1:0] m_tuser,   // [1:0] status
	output logic                m_tlast
);

	logic fr_vld, fr_rdy;
	cmd_t fr_cmd;
	logic bk_vld, bk_rdy;
	cmd_t bk_cmd;

	// input decode
	slpq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_vld  (fr_vld),
		.cmd_rdy  (fr_rdy),
		.cmd      (fr_cmd)
	);

	// command queue
	slpq_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_vld (fr_vld),
		.push_rdy (fr_rdy),
		.push_cmd (fr_cmd),
		.pop_vld  (bk_vld),
		.pop_rdy  (bk_rdy),
		.pop_cmd  (bk_cmd)
	);

	// cell row and output
	slpq_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_vld  (bk_vld),
		.cmd_rdy  (bk_rdy),
		.cmd      (bk_cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted-list priority queue. Commands go in on
// the slave stream; a scoreboard keeps its own ascending store and predicts
// every word of the master stream. Both streams idle at random; the random
// part runs in fill, drain and mixed phases so the store reaches full and empty.
// ----------------------------------------------------------------------------
module tb_top;
	import slpq_pkg::*;

	localparam int unsigned CAP = DEF_CAPACITY;
	// opcodes the block accepts and ignores
	localparam logic [OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;
	localparam int RANDOM_CMDS  = 350;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_LIMIT = 10;
	localparam int IDLE_PCT     = 35;

	// one word on the master stream
	typedef struct {
		logic [VALUE_W-1:0]  data;
		logic [STATUS_W-1:0] status;
		logic                last;
	} word_t;

	// predicts master words from accepted commands and checks them in order
	class pq_scoreboard;
		logic signed [VALUE_W-1:0] stored [CAP];
		int unsigned               fill;
		word_t                     expected_words [$];
		int unsigned               mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function void push_word(logic [VALUE_W-1:0] d, logic [STATUS_W-1:0] s, logic l);
			word_t w;
			w.data = d;
			w.status = s;
			w.last = l;
			expected_words.insert(expected_words.size(), w);
		endfunction

		function void note_command(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] value);
			int unsigned pos;
			logic signed [VALUE_W-1:0] head;
			case (op)
			OP_INSERT: begin
				if (fill >= CAP) begin
					push_word('0, ST_FULL, 1'b1);
				end else begin
					// new value goes ahead of any equal entries
					pos = 0;
					while (pos < fill && stored[pos] < $signed(value))
						pos++;
					for (int unsigned i = fill; i > pos; i--)
						stored[i] = stored[i-1];
					stored[pos] = value;
					fill++;
					push_word('0, ST_OK, 1'b1);
				end
			end
			OP_PEEK: begin
				if (fill == 0)
					push_word('0, ST_EMPTY, 1'b1);
				else
					push_word(stored[0], ST_OK, 1'b1);
			end
			OP_POP: begin
				if (fill == 0) begin
					push_word('0, ST_EMPTY, 1'b1);
				end else begin
					head = stored[0];
					for (int unsigned i = 1; i < fill; i++)
						stored[i-1] = stored[i];
					fill--;
					push_word(head, ST_OK, 1'b1);
				end
			end
			OP_CLEAR: begin
				fill = 0;
				push_word('0, ST_OK, 1'b1);
			end
			OP_LIST: begin
				if (fill == 0) begin
					push_word('0, ST_EMPTY, 1'b1);
				end else begin
					for (int unsigned i = 0; i < fill; i++)
						push_word(stored[i], ST_OK, i + 1 == fill);
				end
			end
			default: begin
				// spare opcodes leave no word
			end
			endcase
		endfunction

		function void check_word(logic [VALUE_W-1:0] d, logic [STATUS_W-1:0] s, logic l);
			word_t w;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected word: data %h status %0d last %0b", d, s, l);
				return;
			end
			w = expected_words.pop_front();
			if (w.data !== d || w.status !== s || w.last !== l) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: expected data %h status %0d last %0b, got data %h status %0d last %0b",
						w.data, w.status, w.last, d, s, l);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [VALUE_W-1:0]  s_tdata = '0;
	logic [OPCODE_W-1:0] s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [VALUE_W-1:0]  m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic                m_tlast;
	// window of the run with no idling on either side
	logic                calm = 1'b0;

	pq_scoreboard sb = new();

	sorted_list_priority_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] value
		.s_tuser  (s_tuser),   // [2:0] opcode
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] data
		.m_tuser  (m_tuser),   // [1:0] status
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// sink backpressure
	initial begin
		forever begin
			@(posedge clk);
			m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// signals are stable from the falling edge to the accepting rising edge
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tuser, m_tlast);
	end

	// one command word, with a random gap ahead of it
	task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value);
		bit taken;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= value;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		sb.note_command(op, value);
	endtask

	// many small values so equal entries are common, plus full range and extremes
	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned kind;
		int near;
		kind = $urandom_range(0, 9);
		near = $urandom_range(0, 8);
		if (kind < 4)
			return $urandom();
		else if (kind < 8)
			return near - 4;
		else if (kind == 8)
			return {1'b1, {(VALUE_W-1){1'b0}}};
		else
			return {1'b0, {(VALUE_W-1){1'b1}}};
	endfunction

	// phase 0 fills the store, phase 1 drains it, other phases mix
	function automatic logic [OPCODE_W-1:0] pick_op(int phase);
		int unsigned roll;
		int unsigned rest;
		int unsigned ins_pct;
		int unsigned pop_pct;
		roll = $urandom_range(0, 99);
		rest = $urandom_range(0, 99);
		case (phase)
		0: begin
			ins_pct = 80;
			pop_pct = 6;
		end
		1: begin
			ins_pct = 20;
			pop_pct = 55;
		end
		default: begin
			ins_pct = 45;
			pop_pct = 25;
		end
		endcase
		if (roll < ins_pct)
			return OP_INSERT;
		else if (roll < ins_pct + pop_pct)
			return OP_POP;
		else if (rest < 35)
			return OP_PEEK;
		else if (rest < 75)
			return OP_LIST;
		else if (rest < 88)
			return OP_CLEAR;
		else
			return OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
	endfunction

	initial begin
		logic [OPCODE_W-1:0] op;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store on every reading opcode
		send_cmd(OP_CLEAR, '0);
		send_cmd(OP_PEEK, '0);
		send_cmd(OP_POP, '1);
		send_cmd(OP_LIST, '0);
		// extremes, duplicates and ordering across the sign boundary
		send_cmd(OP_INSERT, 32'd0);
		send_cmd(OP_INSERT, 32'h7fff_ffff);
		send_cmd(OP_INSERT, 32'h8000_0000);
		send_cmd(OP_INSERT, 32'hffff_ffff);
		send_cmd(OP_INSERT, 32'd0);
		send_cmd(OP_INSERT, 32'd5);
		send_cmd(OP_PEEK, '0);
		send_cmd(OP_LIST, '0);
		send_cmd(OP_POP, '0);
		send_cmd(OP_POP, '0);
		// spare opcodes change nothing
		send_cmd(OP_SPARE_LO, '1);
		send_cmd(OP_SPARE_MID, '1);
		send_cmd(OP_SPARE_HI, '1);
		send_cmd(OP_INSERT, 32'h5555_5555);
		send_cmd(OP_INSERT, 32'haaaa_aaaa);
		send_cmd(OP_LIST, '0);
		send_cmd(OP_CLEAR, '1);
		send_cmd(OP_LIST, '0);

		for (int k = 0; k < RANDOM_CMDS; k++) begin
			calm <= (k >= 120 && k < 200);
			op = pick_op((k / 60) % 3);
			send_cmd(op, (op == OP_INSERT) ? pick_value() : $urandom());
		end
		s_tvalid <= 1'b0;

		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
